### rtl/mmcn_pkg.sv
// ----------------------------------------------------------------------------
// mmcn_pkg
// shared types and constants of the magnetometer calibrate and normalize block
// ----------------------------------------------------------------------------
`default_nettype none

package mmcn_pkg;

  localparam int unsigned AXES_MAX = 3;
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned Q_FRAC   = 14;
  // quotient bits kept by the divider, larger quotients saturate early
  localparam int unsigned QUO_W    = 17;
  localparam int unsigned STEP_W   = $clog2(QUO_W);
  localparam int unsigned OVF_BIT  = 3;

  localparam logic [1:0] REQ_MEASURE = 2'd0;
  localparam logic [1:0] REQ_CAL     = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [CNT_W-1:0]  CAL_ITER_RESET = 16'd1000;
  localparam logic [AXIS_W-1:0] Q_SAT_POS      = 16'h7fff;
  localparam logic [AXIS_W-1:0] Q_SAT_NEG      = 16'h8000;
  localparam logic [QUO_W-1:0]  Q_MAG_LIM      = 17'd32768;
  localparam logic [AXIS_W-1:0] BOUND_MIN_RST  = 16'h8000;
  localparam logic [AXIS_W-1:0] BOUND_MAX_RST  = 16'h7fff;

  typedef struct packed {
    logic load;
    logic step;
    logic seed;
    logic widen;
    logic commit;
  } lane_cmd_t;

  typedef struct packed {
    logic [AXES_MAX-1:0][AXIS_W-1:0] norm;
    logic                            ok;
    logic                            bad;
    logic                            done;
  } res_t;

endpackage

`default_nettype wire

### rtl/magnetometer_minmax_calibrate_normalize.sv
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrate_normalize
// min/max hard-iron calibration and Q2.14 normalization of magnetometer samples
// ----------------------------------------------------------------------------
// input channel: in_valid_i/in_ready_o with one sample per transfer (request
// type, three little-endian axis byte pairs, status byte)
// output channel: out_valid_o/out_ready_i with one result per sample
// config channel: cfg_valid_i/cfg_ready_o writes cal_iterations, always ready
// path: calibration, restart, flagged and bad-bounds samples pass through the
// holding register into the output register; a normalized sample first runs
// the 17-step bit-serial dividers, one per axis, running in parallel
// flow: one sample at a time, none is taken while a division runs;
// one finished result can wait in a holding register while the output stalls,
// a further sample is taken once that register has moved on
// reset: committed bounds span the full range, calibration idle,
// cal_iterations 1000, both channels empty
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_minmax_calibrate_normalize import mmcn_pkg::*; #(
  parameter int unsigned AXES = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [7:0]        x_low_i,
  input  wire logic [7:0]        x_high_i,
  input  wire logic [7:0]        y_low_i,
  input  wire logic [7:0]        y_high_i,
  input  wire logic [7:0]        z_low_i,
  input  wire logic [7:0]        z_high_i,
  input  wire logic [7:0]        status_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [AXIS_W-1:0] norm_x_o,
  output logic signed [AXIS_W-1:0] norm_y_o,
  output logic signed [AXIS_W-1:0] norm_z_o,
  output logic                   result_ok_o,
  output logic                   bounds_bad_o,
  output logic                   cal_done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEED,
    PH_COLLECT
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  upd_cnt_q, upd_cnt_d;
  logic [CNT_W-1:0]  iters_q, iters_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pend_q, pend_d;
  res_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic signed [AXIS_W-1:0]        axis_m [AXES_MAX];
  logic [AXES-1:0]                 lane_bad;
  logic [AXES-1:0][AXIS_W-1:0]     lane_norm;
  logic                            any_bad;
  logic [AXES_MAX-1:0][AXIS_W-1:0] merged_norm;
  lane_cmd_t                       cmd;

  logic             in_fire, sample_ok, out_load;
  logic [CNT_W:0]   cnt_plus;
  logic             commit_hit;

  assign axis_m[0] = {x_high_i, x_low_i};
  assign axis_m[1] = {y_high_i, y_low_i};
  assign axis_m[2] = {z_high_i, z_low_i};

  assign in_ready_o  = (state_q == S_IDLE) && !pend_q;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign sample_ok   = !status_byte_i[OVF_BIT];
  assign cnt_plus    = {1'b0, upd_cnt_q} + (CNT_W+1)'(1);
  assign commit_hit  = (cnt_plus >= {1'b0, iters_q});
  assign out_load    = pend_q && (!out_valid_q || out_ready_i);

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    mmcn_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .sample_i (axis_m[i]),
      .bad_o    (lane_bad[i]),
      .norm_o   (lane_norm[i])
    );
  end

  mmcn_merge #(
    .AXES (AXES)
  ) u_merge (
    .lane_bad_i  (lane_bad),
    .lane_norm_i (lane_norm),
    .any_bad_o   (any_bad),
    .norm_o      (merged_norm)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    upd_cnt_d   = upd_cnt_q;
    iters_d     = iters_q;
    step_d      = step_q;
    pend_d      = pend_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd         = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      iters_d = cfg_data_i;
    end

    if (out_load) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d    = '0;
          res_d.ok = sample_ok;
          pend_d   = 1'b1;
          case (req_type_i)
            REQ_RESTART: begin
              phase_d   = PH_SEED;
              upd_cnt_d = '0;
            end
            REQ_MEASURE: begin
              if (sample_ok && any_bad) begin
                res_d.bad = 1'b1;
              end else if (sample_ok) begin
                cmd.load = 1'b1;
                pend_d   = 1'b0;
                step_d   = '0;
                state_d  = S_DIV;
              end
            end
            REQ_CAL: begin
              if (sample_ok && phase_q == PH_SEED) begin
                cmd.seed  = 1'b1;
                phase_d   = PH_COLLECT;
                upd_cnt_d = '0;
              end else if (sample_ok && phase_q == PH_COLLECT) begin
                cmd.widen = 1'b1;
                if (commit_hit) begin
                  cmd.commit = 1'b1;
                  phase_d    = PH_IDLE;
                  upd_cnt_d  = '0;
                  res_d.done = 1'b1;
                end else begin
                  upd_cnt_d = cnt_plus[CNT_W-1:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUO_W - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d      = '0;
        res_d.ok   = 1'b1;
        res_d.norm = merged_norm;
        pend_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      upd_cnt_q   <= '0;
      iters_q     <= CAL_ITER_RESET;
      step_q      <= '0;
      pend_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      upd_cnt_q   <= upd_cnt_d;
      iters_q     <= iters_d;
      step_q      <= step_d;
      pend_q      <= pend_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign norm_x_o     = out_q.norm[0];
  assign norm_y_o     = out_q.norm[1];
  assign norm_z_o     = out_q.norm[2];
  assign result_ok_o  = out_q.ok;
  assign bounds_bad_o = out_q.bad;
  assign cal_done_o   = out_q.done;

endmodule

`default_nettype wire

### rtl/mmcn_lane.sv
// ----------------------------------------------------------------------------
// mmcn_lane
// one axis: working and committed bounds plus a bit-serial normalizing divider
// ----------------------------------------------------------------------------
`default_nettype none

module mmcn_lane import mmcn_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lane_cmd_t                cmd_i,
  input  wire logic signed [AXIS_W-1:0] sample_i,
  output logic                          bad_o,
  output logic        [AXIS_W-1:0]      norm_o
);

  localparam int unsigned DIFF_W = AXIS_W + 3;
  localparam int unsigned MAG_W  = AXIS_W + 2;

  logic signed [AXIS_W-1:0] cmin_q, cmax_q, wmin_q, wmax_q;
  logic signed [AXIS_W-1:0] wmin_nxt, wmax_nxt;

  logic [QUO_W-1:0]  rem_q, dvd_q, quo_q;
  logic [AXIS_W-1:0] den_q;
  logic              neg_q, sat_q;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] diff_abs;
  logic        [MAG_W-1:0]  mag;
  logic        [AXIS_W:0]   den_full;
  logic                     sat_now;
  logic        [QUO_W-1:0]  rem_sh;
  logic                     fits;

  assign wmin_nxt = (sample_i < wmin_q) ? sample_i : wmin_q;
  assign wmax_nxt = (sample_i > wmax_q) ? sample_i : wmax_q;

  assign bad_o = (cmax_q <= cmin_q);

  // 2m - min - max, later scaled by 2^Q_FRAC through the dividend layout
  assign diff = {{2{sample_i[AXIS_W-1]}}, sample_i, 1'b0}
              - {{3{cmin_q[AXIS_W-1]}}, cmin_q}
              - {{3{cmax_q[AXIS_W-1]}}, cmax_q};
  assign diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
  assign mag      = diff_abs[MAG_W-1:0];
  assign den_full = {cmax_q[AXIS_W-1], cmax_q} - {cmin_q[AXIS_W-1], cmin_q};
  assign sat_now  = ({1'b0, mag} >= {den_full[AXIS_W-1:0], 3'b000});

  assign rem_sh = {rem_q[QUO_W-2:0], dvd_q[QUO_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    if (sat_q) begin
      norm_o = neg_q ? Q_SAT_NEG : Q_SAT_POS;
    end else if (neg_q) begin
      norm_o = (quo_q >= Q_MAG_LIM) ? Q_SAT_NEG : (~quo_q[AXIS_W-1:0] + AXIS_W'(1));
    end else begin
      norm_o = (quo_q >= Q_MAG_LIM) ? Q_SAT_POS : quo_q[AXIS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmin_q <= BOUND_MIN_RST;
      cmax_q <= BOUND_MAX_RST;
      wmin_q <= '0;
      wmax_q <= '0;
    end else begin
      if (cmd_i.seed) begin
        wmin_q <= sample_i;
        wmax_q <= sample_i;
      end
      if (cmd_i.widen) begin
        wmin_q <= wmin_nxt;
        wmax_q <= wmax_nxt;
      end
      if (cmd_i.commit) begin
        cmin_q <= wmin_nxt;
        cmax_q <= wmax_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= {2'b00, mag[MAG_W-1:3]};
      dvd_q <= {mag[2:0], {Q_FRAC{1'b0}}};
      quo_q <= '0;
      den_q <= den_full[AXIS_W-1:0];
      neg_q <= diff[DIFF_W-1];
      sat_q <= sat_now;
    end else if (cmd_i.step) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/mmcn_merge.sv
// ----------------------------------------------------------------------------
// mmcn_merge
// combines the lane flags and lane results into one result word
// ----------------------------------------------------------------------------
`default_nettype none

module mmcn_merge import mmcn_pkg::*; #(
  parameter int unsigned AXES = 3
) (
  input  wire logic [AXES-1:0]             lane_bad_i,
  input  wire logic [AXES-1:0][AXIS_W-1:0] lane_norm_i,
  output logic                             any_bad_o,
  output logic [AXES_MAX-1:0][AXIS_W-1:0]  norm_o
);

  assign any_bad_o = |lane_bad_i;

  always_comb begin
    norm_o = '0;
    for (int i = 0; i < AXES; i++) begin
      norm_o[i] = lane_norm_i[i];
    end
  end

endmodule

`default_nettype wire

### rtl/mmcn_checker.sv
// ----------------------------------------------------------------------------
// mmcn_checker
// port-level checks of the calibrate and normalize block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module mmcn_checker import mmcn_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [AXIS_W-1:0] norm_x_o,
  input wire logic [AXIS_W-1:0] norm_y_o,
  input wire logic [AXIS_W-1:0] norm_z_o,
  input wire logic              result_ok_o,
  input wire logic              bounds_bad_o,
  input wire logic              cal_done_o
);

  // flagged sample carries nothing but the flag
  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_ok_o |->
      !bounds_bad_o && !cal_done_o && norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0)
    else $error("overflow result carries data");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bounds_bad_o |->
      result_ok_o && !cal_done_o && norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0)
    else $error("bad bounds result not cleared");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cal_done_o |->
      result_ok_o && norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0)
    else $error("commit result carries norm data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(norm_x_o) && $stable(norm_y_o) && $stable(norm_z_o)
      && $stable(cal_done_o))
    else $error("stalled result changed");

endmodule

bind magnetometer_minmax_calibrate_normalize mmcn_checker u_mmcn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .norm_x_o     (norm_x_o),
  .norm_y_o     (norm_y_o),
  .norm_z_o     (norm_z_o),
  .result_ok_o  (result_ok_o),
  .bounds_bad_o (bounds_bad_o),
  .cal_done_o   (cal_done_o)
);

`default_nettype wire
